// ----- rtl/dgpa_pkg.sv -----
`timescale 1ns / 1ps

package dgpa_pkg;

    localparam int COORD_BITS = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;
    localparam int PIX_DATA_BITS = 32;
    localparam int RES_DATA_BITS = 128;

    // Point coordinates after adding a signed disparity: one bit of growth plus sign.
    localparam int PT_BITS = COORD_BITS + 2;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic signed [PT_BITS-1:0] t_point;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GRID_SPACING = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_IMAGE_HEIGHT = 3'd2,
        REG_LEFT_LINEAR  = 3'd3,
        REG_LEFT_OFFSET  = 3'd4,
        REG_RIGHT_LINEAR = 3'd5,
        REG_RIGHT_OFFSET = 3'd6
    } t_reg_index;

    localparam logic [15:0] RST_GRID_SPACING = 16'd100;
    localparam logic [15:0] RST_IMAGE_SIZE   = 16'd1024;
    localparam logic [63:0] RST_LINEAR       = 64'h1000_0000_1000_0000;

    typedef struct packed {
        t_coord col;
        t_coord row;
        logic   hit;
    } t_raster;

    // Advance a counter by one, wrapping at the limit; a zero limit acts as one.
    function automatic t_coord bump(input t_coord v, input logic [15:0] limit);
        t_coord lim;
        t_coord nxt;
        lim = (limit == '0) ? t_coord'(1) : t_coord'(limit);
        nxt = v + t_coord'(1);
        return (nxt >= lim) ? '0 : nxt;
    endfunction

endpackage

// ----- rtl/dgpa_raster.sv -----
`timescale 1ns / 1ps

module dgpa_raster (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic [15:0]            i_grid_spacing,
    input  logic [15:0]            i_image_width,
    input  logic [15:0]            i_image_height,
    output dgpa_pkg::t_raster      o_pos
);
    import dgpa_pkg::*;

    t_coord r_col_pos, r_row_pos, r_col_phase, r_row_phase;
    t_coord n_col_pos, n_row_pos, n_col_phase, n_row_phase;

    assign o_pos.col = r_col_pos;
    assign o_pos.row = r_row_pos;
    assign o_pos.hit = (r_col_phase == '0) && (r_row_phase == '0);

    always_comb begin
        n_col_pos   = bump(r_col_pos, i_image_width);
        n_row_pos   = r_row_pos;
        n_row_phase = r_row_phase;
        if (n_col_pos == '0) begin
            n_col_phase = '0;
            n_row_pos   = bump(r_row_pos, i_image_height);
            n_row_phase = (n_row_pos == '0) ? '0 : bump(r_row_phase, i_grid_spacing);
        end else begin
            n_col_phase = bump(r_col_phase, i_grid_spacing);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos   <= '0;
            r_row_pos   <= '0;
            r_col_phase <= '0;
            r_row_phase <= '0;
        end else if (i_adv) begin
            r_col_pos   <= n_col_pos;
            r_row_pos   <= n_row_pos;
            r_col_phase <= n_col_phase;
            r_row_phase <= n_row_phase;
        end
    end

endmodule

// ----- rtl/dgpa_map.sv -----
`timescale 1ns / 1ps

module dgpa_map (
    input  logic [63:0]          i_linear,
    input  logic [63:0]          i_offset,
    input  dgpa_pkg::t_point     i_x,
    input  dgpa_pkg::t_point     i_y,
    output logic signed [31:0]   o_x,
    output logic signed [31:0]   o_y
);
    import dgpa_pkg::*;

    localparam int PROD_BITS = PT_BITS + 16;
    localparam int SUM_BITS  = PROD_BITS + 2;

    logic signed [15:0] c_a, c_b, c_d, c_e;
    logic signed [31:0] c_c, c_f;
    logic signed [PROD_BITS-1:0] p_ax, p_by, p_dx, p_ey;
    logic signed [SUM_BITS-1:0] s_x, s_y;

    assign c_b = i_linear[15:0];
    assign c_a = i_linear[31:16];
    assign c_d = i_linear[47:32];
    assign c_e = i_linear[63:48];
    assign c_c = i_offset[31:0];
    assign c_f = i_offset[63:32];

    assign p_ax = c_a * i_x;
    assign p_by = c_b * i_y;
    assign p_dx = c_d * i_x;
    assign p_ey = c_e * i_y;

    assign s_x = SUM_BITS'(p_ax) + SUM_BITS'(p_by) + SUM_BITS'(c_c);
    assign s_y = SUM_BITS'(p_dx) + SUM_BITS'(p_ey) + SUM_BITS'(c_f);

    // Saturate when the bits above the 32-bit result disagree with its sign.
    function automatic logic signed [31:0] sat32(input logic signed [SUM_BITS-1:0] v);
        logic fits;
        fits = (v[SUM_BITS-1:31] == '0) || (v[SUM_BITS-1:31] == '1);
        if (fits) begin
            return v[31:0];
        end
        return v[SUM_BITS-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    assign o_x = sat32(s_x);
    assign o_y = sat32(s_y);

endmodule

// ----- rtl/disparity_grid_pair_affine.sv -----
`timescale 1ns / 1ps

// Disparity grid sampler with a pair of affine maps.
// The slave stream carries one disparity pixel per transfer in raster order:
// tuser is the valid mark, tdata holds disp_dx in [15:0] and disp_dy in [31:16].
// Column and row are counted internally and wrap at image_width and image_height.
// A valid pixel that lands on the grid (both phases zero) produces one result on
// the master stream: tdata holds left_x, left_y, right_x, right_y, 32 bits each,
// lowest first, Q.12 and saturated. Other pixels produce nothing.
// Throughput is one pixel per cycle while the master stream is not stalled.
// A sampled pixel is registered in the input register at its transfer and
// moves into the result register once that is free, raising o_m_tvalid; the
// four multipliers per map sit in the single pass between the two registers.
// When the receiver stalls, the waiting result holds and one more sampled pixel
// can be taken into the input register; after that tready drops until the
// result is taken. Unsampled pixels are always taken while the input register
// can advance. Reset clears the counters and both pipeline stages and loads the
// register defaults (spacing 100, 1024 x 1024, identity maps). Registers are
// written through the plain write port; the user must do so only while the
// stream is idle, as the block itself does not enforce it.
module disparity_grid_pair_affine (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [dgpa_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [dgpa_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // disp_dx [15:0], disp_dy [31:16]
    input  logic [dgpa_pkg::PIX_DATA_BITS-1:0]      i_s_tdata,
    // disp_valid [0]
    input  logic                                    i_s_tuser,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // left_x [31:0], left_y [63:32], right_x [95:64], right_y [127:96]
    output logic [dgpa_pkg::RES_DATA_BITS-1:0]      o_m_tdata
);
    import dgpa_pkg::*;

    logic [15:0] r_grid_spacing, r_image_width, r_image_height;
    logic [63:0] r_left_linear, r_left_offset, r_right_linear, r_right_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_spacing <= RST_GRID_SPACING;
            r_image_width  <= RST_IMAGE_SIZE;
            r_image_height <= RST_IMAGE_SIZE;
            r_left_linear  <= RST_LINEAR;
            r_left_offset  <= '0;
            r_right_linear <= RST_LINEAR;
            r_right_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GRID_SPACING: r_grid_spacing <= i_cfg_data[15:0];
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[15:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[15:0];
                REG_LEFT_LINEAR:  r_left_linear  <= i_cfg_data;
                REG_LEFT_OFFSET:  r_left_offset  <= i_cfg_data;
                REG_RIGHT_LINEAR: r_right_linear <= i_cfg_data;
                REG_RIGHT_OFFSET: r_right_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_raster pos;
    logic    s_accept;
    logic    sample;
    logic    out_free;
    logic    s1_adv;

    logic        r_s1_valid;
    t_coord      r_s1_col, r_s1_row;
    logic [15:0] r_s1_dx, r_s1_dy;

    assign out_free   = !o_m_tvalid || i_m_tready;
    assign o_s_tready = !r_s1_valid || out_free;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign sample     = s_accept && i_s_tuser && pos.hit;
    assign s1_adv     = r_s1_valid && out_free;

    dgpa_raster u_raster (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (s_accept),
        .i_grid_spacing (r_grid_spacing),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_pos          (pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sample) begin
            r_s1_col <= pos.col;
            r_s1_row <= pos.row;
            r_s1_dx  <= i_s_tdata[15:0];
            r_s1_dy  <= i_s_tdata[31:16];
        end
    end

    t_point lx, ly, rx, ry;
    logic signed [31:0] m_lx, m_ly, m_rx, m_ry;

    assign lx = t_point'({2'b00, r_s1_col});
    assign ly = t_point'({2'b00, r_s1_row});
    assign rx = lx + t_point'($signed(r_s1_dx));
    assign ry = ly + t_point'($signed(r_s1_dy));

    dgpa_map u_map_left (
        .i_linear (r_left_linear),
        .i_offset (r_left_offset),
        .i_x      (lx),
        .i_y      (ly),
        .o_x      (m_lx),
        .o_y      (m_ly)
    );

    dgpa_map u_map_right (
        .i_linear (r_right_linear),
        .i_offset (r_right_offset),
        .i_x      (rx),
        .i_y      (ry),
        .o_x      (m_rx),
        .o_y      (m_ry)
    );

    logic                     r_out_valid;
    logic [RES_DATA_BITS-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {m_ry, m_rx, m_ly, m_lx};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_tready)
        else $error("input stalled with empty result register");

    // A sampled transfer always lands in the input stage.
    a_sample_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample |=> r_s1_valid)
        else $error("sampled pixel was dropped");

    // A held item in the input stage moves to the output once it frees up.
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("input stage advanced without producing a result");

    // A stalled result is not lost.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> r_out_valid)
        else $error("result dropped during stall");

endmodule

// ----- tb/tb_disparity_grid_pair_affine.sv -----
`timescale 1ns / 1ps

module tb_disparity_grid_pair_affine;
    import dgpa_pkg::*;

    class point_pair_board;
        bit [15:0] spacing;
        bit [15:0] width;
        bit [15:0] height;
        bit [63:0] left_lin;
        bit [63:0] left_off;
        bit [63:0] right_lin;
        bit [63:0] right_off;
        bit [15:0] col;
        bit [15:0] row;
        bit [15:0] col_ph;
        bit [15:0] row_ph;
        bit [127:0] expected_pairs[$];
        int errors;
        string field_names[4] = '{"left_x", "left_y", "right_x", "right_y"};

        function new();
            spacing = RST_GRID_SPACING;
            width = RST_IMAGE_SIZE;
            height = RST_IMAGE_SIZE;
            left_lin = RST_LINEAR;
            right_lin = RST_LINEAR;
            left_off = '0;
            right_off = '0;
            col = '0;
            row = '0;
            col_ph = '0;
            row_ph = '0;
            errors = 0;
        endfunction

        function void set_reg(t_reg_index idx, bit [63:0] value);
            case (idx)
                REG_GRID_SPACING: spacing = value[15:0];
                REG_IMAGE_WIDTH:  width = value[15:0];
                REG_IMAGE_HEIGHT: height = value[15:0];
                REG_LEFT_LINEAR:  left_lin = value;
                REG_LEFT_OFFSET:  left_off = value;
                REG_RIGHT_LINEAR: right_lin = value;
                REG_RIGHT_OFFSET: right_off = value;
                default: ;
            endcase
        endfunction

        // A zero limit behaves like one; anything at or past the limit wraps to zero.
        static function bit [15:0] advance(bit [15:0] v, bit [15:0] lim);
            bit [15:0] n;
            if (lim == 16'd0) lim = 16'd1;
            n = v + 16'd1;
            return (n >= lim) ? 16'd0 : n;
        endfunction

        static function bit [31:0] clamp32(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        endfunction

        static function bit [63:0] map_point(bit [63:0] lin, bit [63:0] off, longint x,
                                             longint y);
            longint a, b, c, d, e, f;
            b = $signed(lin[15:0]);
            a = $signed(lin[31:16]);
            d = $signed(lin[47:32]);
            e = $signed(lin[63:48]);
            c = $signed(off[31:0]);
            f = $signed(off[63:32]);
            return {clamp32(d * x + e * y + f), clamp32(a * x + b * y + c)};
        endfunction

        function void note_pixel(bit valid, bit [15:0] dx, bit [15:0] dy);
            longint x, y;
            bit [63:0] lp, rp;
            if (valid && col_ph == 16'd0 && row_ph == 16'd0) begin
                x = col;
                y = row;
                lp = map_point(left_lin, left_off, x, y);
                rp = map_point(right_lin, right_off, x + longint'($signed(dx)),
                               y + longint'($signed(dy)));
                expected_pairs.push_back({rp, lp});
            end
            col = advance(col, width);
            if (col == 16'd0) begin
                col_ph = '0;
                row = advance(row, height);
                if (row == 16'd0) begin
                    row_ph = '0;
                end else begin
                    row_ph = advance(row_ph, spacing);
                end
            end else begin
                col_ph = advance(col_ph, spacing);
            end
        endfunction

        function void check_pair(bit [127:0] got);
            bit [127:0] want;
            if (expected_pairs.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_pairs.pop_front();
            for (int i = 0; i < 4; i++) begin
                if (want[32*i +: 32] != got[32*i +: 32]) begin
                    $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                             field_names[i], $signed(want[32*i +: 32]),
                             $signed(got[32*i +: 32]));
                    errors++;
                end
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_s_tvalid = 1'b0;
    logic                     o_s_tready;
    logic [PIX_DATA_BITS-1:0] i_s_tdata = '0;
    logic                     i_s_tuser = 1'b0;
    logic                     o_m_tvalid;
    logic                     i_m_tready = 1'b0;
    logic [RES_DATA_BITS-1:0] o_m_tdata;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    point_pair_board board;

    always #5 i_clk = ~i_clk;

    disparity_grid_pair_affine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_pair(o_m_tdata);
    end

    // Writes every register in index order; called at a falling edge while idle.
    task automatic load_regs(input logic [15:0] spacing, input logic [15:0] width,
                             input logic [15:0] height, input logic [63:0] ll,
                             input logic [63:0] lo, input logic [63:0] rl,
                             input logic [63:0] ro);
        logic [63:0] vals[7];
        t_reg_index idx;
        vals = '{64'(spacing), 64'(width), 64'(height), ll, lo, rl, ro};
        idx = REG_GRID_SPACING;
        for (int i = 0; i < idx.num(); i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= vals[i];
            board.set_reg(idx, vals[i]);
            @(negedge i_clk);
            idx = idx.next();
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input bit valid, input logic [15:0] dx, input logic [15:0] dy);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {dy, dx};
        i_s_tuser <= valid;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_pixel(valid, dx, dy);
        @(negedge i_clk);
    endtask

    // Waits with the source idle until every expected result has been checked.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (board.expected_pairs.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h1000;
            3: return 16'hF000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'($signed(20'($urandom)));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_disp();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return 16'($signed(6'($urandom)));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_size(input int span);
        case ($urandom_range(0, 11))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, span));
        endcase
    endfunction

    initial begin
        int idle_src[4];
        int idle_sink[4];
        idle_src = '{0, 60, 0, 25};
        idle_sink = '{0, 0, 60, 25};
        board = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults: the first pixel sits on the grid, the next ones do not.
        send_pixel(1'b1, 16'h8000, 16'h7FFF);
        send_pixel(1'b1, 16'h7FFF, 16'h8000);
        send_pixel(1'b0, 16'hFFFF, 16'h0000);
        drain();

        // Zero spacing and zero width with the column past the width, saturating maps.
        load_regs(16'd0, 16'd0, 16'd3,
                  {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
                  {32'h8000_0000, 32'h7FFF_FFFF},
                  {4{16'h7FFF}},
                  {32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_pixel(1'b1, 16'h7FFF, 16'h7FFF);
        send_pixel(1'b1, 16'h8000, 16'h8000);
        send_pixel(1'b0, 16'h7FFF, 16'h8000);
        send_pixel(1'b1, 16'h8000, 16'h7FFF);
        send_pixel(1'b1, 16'h0000, 16'hFFFF);
        drain();

        // Largest sizes and spacing.
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 64'h0, {64{1'b1}},
                  {4{16'h8000}}, {32'h8000_0000, 32'h8000_0000});
        repeat (4) send_pixel(1'b1, 16'($urandom), 16'($urandom));
        drain();

        // Width and spacing below the current column and phase, then a spacing
        // change in the middle of a frame.
        load_regs(16'd3, 16'd3, 16'd4, RST_LINEAR, 64'h0, RST_LINEAR,
                  {32'hFFFF_F000, 32'h0000_1000});
        repeat (6) send_pixel(1'b1, pick_disp(), pick_disp());
        drain();
        load_regs(16'd2, 16'd5, 16'd4, RST_LINEAR, {32'h0000_0800, 32'hFFFF_F800},
                  {16'h1000, 16'h0800, 16'hF800, 16'h1000}, 64'h0);
        repeat (6) send_pixel(1'b1, pick_disp(), pick_disp());
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            src_idle_pct = idle_src[ph % 4];
            sink_stall_pct = idle_sink[ph % 4];
            load_regs(($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4)) : 16'($urandom),
                      pick_size(12), pick_size(8),
                      {pick_coef(), pick_coef(), pick_coef(), pick_coef()},
                      {pick_offset(), pick_offset()},
                      {pick_coef(), pick_coef(), pick_coef(), pick_coef()},
                      {pick_offset(), pick_offset()});
            repeat (90) send_pixel($urandom_range(0, 9) < 8, pick_disp(), pick_disp());
            drain();
        end

        if (board.errors == 0 && board.expected_pairs.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dgpa_pkg.sv
rtl/dgpa_raster.sv
rtl/dgpa_map.sv
rtl/disparity_grid_pair_affine.sv
tb/tb_disparity_grid_pair_affine.sv
